### sv/backlight_pulse_count_dimmer_defines.svh
// assertion macros for the backlight pulse count dimmer
`ifndef BACKLIGHT_PULSE_COUNT_DIMMER_DEFINES_SVH
`define BACKLIGHT_PULSE_COUNT_DIMMER_DEFINES_SVH

// same-cycle implication
`define BPCD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/bpcd_pkg.sv
// shared types and constants of the backlight pulse count dimmer
package bpcd_pkg;

    localparam int STEP_COUNT_DEF = 16;
    localparam int STEP_COUNT_MAX = 32;

    localparam int LEVEL_W    = 8;
    localparam int STEP_W     = $clog2(STEP_COUNT_MAX + 1);
    localparam int STEP_NOW_W = 5;

    localparam logic [LEVEL_W-1:0] LEVEL_OFF  = 8'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_MIN  = 8'd30;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 8'd255;
    localparam logic [LEVEL_W-1:0] BOOT_RESET = 8'd45;
    localparam logic [STEP_W-1:0]  TOP_ON_STEP = 6'd2;

    // floor(x / 225) as (x * RECIP) >> RECIP_SHIFT, exact for x below 2**21 / error term
    localparam int LEVEL_SPAN  = 225;
    localparam int RECIP_SHIFT = 21;
    localparam int RECIP       = (2 ** RECIP_SHIFT + LEVEL_SPAN - 1) / LEVEL_SPAN;
    localparam int RECIP_W     = $clog2(RECIP + 1);
    localparam int PROD_W      = LEVEL_W + $clog2(STEP_COUNT_MAX);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_OFF  = 2'd0,
        ACT_STEP = 2'd1,
        ACT_WAKE = 2'd2
    } t_action;

    typedef struct packed {
        t_action                 act;
        logic [STEP_W-1:0]       times;
        logic [STEP_NOW_W-1:0]   step;
    } t_cmd;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MULT,
        F_DIV,
        F_ISSUE
    } t_front_state;

    typedef enum logic {
        SEL_REQ,
        SEL_BOOT
    } t_map_sel;

endpackage

### sv/bpcd_front.sv
// front end: takes a request, maps it to a step and queues a pulse command when one is needed
module bpcd_front
    import bpcd_pkg::*;
#(
    parameter int STEP_COUNT = STEP_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  logic [LEVEL_W-1:0] i_brightness,
    input  logic [LEVEL_W-1:0] i_boot_brightness,
    input  logic               i_full,
    output logic               o_push,
    output t_cmd               o_cmd
);

    localparam logic [STEP_W-1:0] SC    = STEP_W'(STEP_COUNT);
    localparam logic [STEP_W-1:0] SC_M1 = STEP_W'(STEP_COUNT - 1);
    localparam int QW = PROD_W + RECIP_W;

    t_front_state        r_state, n_state;
    t_map_sel            r_sel, n_sel;
    logic [LEVEL_W-1:0]  r_req, n_req;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic                r_low, n_low;
    logic [STEP_W-1:0]   r_target, n_target;
    logic [STEP_W-1:0]   r_cur, n_cur;
    logic                r_light_on, n_light_on;
    logic                r_first, n_first;

    logic [LEVEL_W-1:0]  w_map_in;
    logic [LEVEL_W-1:0]  w_diff;
    logic [QW-1:0]       w_quot_full;
    logic [STEP_W-1:0]   w_quot;
    logic [STEP_W-1:0]   w_step;

    assign w_map_in    = (r_sel == SEL_REQ) ? r_req : i_boot_brightness;
    assign w_diff      = w_map_in - LEVEL_MIN;
    assign w_quot_full = QW'(r_prod) * QW'(RECIP);
    assign w_quot      = STEP_W'(w_quot_full >> RECIP_SHIFT);
    assign w_step      = r_low ? SC : SC - w_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= F_IDLE;
            r_light_on <= 1'b1;
            r_first    <= 1'b1;
            r_cur      <= STEP_W'(1);
        end else begin
            r_state    <= n_state;
            r_light_on <= n_light_on;
            r_first    <= n_first;
            r_cur      <= n_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel    <= n_sel;
        r_req    <= n_req;
        r_prod   <= n_prod;
        r_low    <= n_low;
        r_target <= n_target;
    end

    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        n_req       = r_req;
        n_prod      = r_prod;
        n_low       = r_low;
        n_target    = r_target;
        n_cur       = r_cur;
        n_light_on  = r_light_on;
        n_first     = r_first;
        o_req_ready = 1'b0;
        o_push      = 1'b0;
        o_cmd.act   = ACT_STEP;
        o_cmd.times = r_target;
        o_cmd.step  = STEP_NOW_W'(r_target);

        case (r_state)
            F_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_req   = i_brightness;
                    n_sel   = SEL_REQ;
                    n_state = (i_brightness == LEVEL_OFF) ? F_ISSUE : F_MULT;
                end
            end
            F_MULT: begin
                n_prod  = PROD_W'(w_diff) * PROD_W'(SC_M1);
                n_low   = w_map_in < LEVEL_MIN;
                n_state = F_DIV;
            end
            F_DIV: begin
                if (r_sel == SEL_REQ) begin
                    n_target = (r_req == LEVEL_MAX && r_light_on) ? TOP_ON_STEP : w_step;
                    // first request while on: assume the step the boot stage left
                    if (r_light_on && r_first) begin
                        n_sel   = SEL_BOOT;
                        n_state = F_MULT;
                    end else begin
                        n_state = F_ISSUE;
                    end
                end else begin
                    n_cur   = w_step - STEP_W'(1);
                    n_first = 1'b0;
                    n_state = F_ISSUE;
                end
            end
            F_ISSUE: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                    if (r_req == LEVEL_OFF) begin
                        o_push      = 1'b1;
                        o_cmd.act   = ACT_OFF;
                        o_cmd.times = STEP_W'(1);
                        o_cmd.step  = STEP_NOW_W'(r_cur);
                        n_light_on  = 1'b0;
                    end else begin
                        if (!r_light_on) begin
                            o_push    = 1'b1;
                            o_cmd.act = ACT_WAKE;
                        end else if (r_cur > r_target) begin
                            // driver wraps past the top step
                            o_push      = 1'b1;
                            o_cmd.times = r_target + SC - r_cur;
                        end else if (r_cur < r_target) begin
                            o_push      = 1'b1;
                            o_cmd.times = r_target - r_cur;
                        end
                        n_cur      = r_target;
                        n_light_on = 1'b1;
                    end
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

endmodule

### sv/bpcd_cmd_queue.sv
// short command queue between front and back end
module bpcd_cmd_queue
    import bpcd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty,
    output logic o_full
);

    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // depth is a power of two, pointers wrap on their own
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= QUEUE_PTR_W'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= QUEUE_PTR_W'(r_rd_ptr + 1'b1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### sv/bpcd_back.sv
// back end: expands a queued command into its run of pulse commands
module bpcd_back
    import bpcd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_head,
    input  logic                  i_empty,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_action               o_action,
    output logic                  o_last,
    output logic [STEP_NOW_W-1:0] o_step
);

    logic [STEP_W-1:0]     r_idx;
    logic                  r_valid;
    t_action               r_action;
    logic                  r_last;
    logic [STEP_NOW_W-1:0] r_step;

    logic              w_load;
    logic              w_final;
    logic [STEP_W-1:0] w_idx_inc;

    assign w_idx_inc = STEP_W'(r_idx + 1'b1);
    assign w_load    = !i_empty && (!r_valid || i_ready);
    assign w_final   = (w_idx_inc == i_head.times);
    assign o_pop     = w_load && w_final;

    assign o_valid  = r_valid;
    assign o_action = r_action;
    assign o_last   = r_last;
    assign o_step   = r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_idx   <= w_final ? '0 : w_idx_inc;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // only the first pulse of a run carries the off or wake kind
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_action <= (r_idx == '0) ? i_head.act : ACT_STEP;
            r_last   <= w_final;
            r_step   <= i_head.step;
        end
    end

endmodule

### sv/backlight_pulse_count_dimmer.sv
// top level of the backlight pulse count dimmer
// request path: off goes from idle to issue; other levels pass multiply, divide and issue, and
// the first request while on runs the two-stage step mapper again for boot; no new request until issue
// back end sends one command per cycle while m_axis_tready is high, holding a run until all are sent
// reset: light on, step 1, first request pending, boot brightness 45, queue and output empty
`include "backlight_pulse_count_dimmer_defines.svh"

module backlight_pulse_count_dimmer
    import bpcd_pkg::*;
#(
    parameter int STEP_COUNT = STEP_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] brightness
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // [1:0] action, [6:2] step_now, [7] zero
    output logic               m_axis_tlast,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [LEVEL_W-1:0] i_cfg_data      // boot_brightness
);

    logic [LEVEL_W-1:0]    r_boot_brightness;
    logic                  w_push;
    t_cmd                  w_cmd;
    logic                  w_pop;
    t_cmd                  w_head;
    logic                  w_empty;
    logic                  w_full;
    t_action               w_action;
    logic [STEP_NOW_W-1:0] w_step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot_brightness <= BOOT_RESET;
        end else if (i_cfg_valid) begin
            r_boot_brightness <= i_cfg_data;
        end
    end

    bpcd_front #(
        .STEP_COUNT (STEP_COUNT)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_valid       (s_axis_tvalid),
        .o_req_ready       (s_axis_tready),
        .i_brightness      (s_axis_tdata),
        .i_boot_brightness (r_boot_brightness),
        .i_full            (w_full),
        .o_push            (w_push),
        .o_cmd             (w_cmd)
    );

    bpcd_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    bpcd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_action (w_action),
        .o_last   (m_axis_tlast),
        .o_step   (w_step)
    );

    assign m_axis_tdata = {1'b0, w_step, w_action};

    `BPCD_ASSERT_SAME(a_push_not_full, i_clk, i_rst_n, w_push, !w_full, "push into full queue")
    `BPCD_ASSERT_SAME(a_pop_not_empty, i_clk, i_rst_n, w_pop, !w_empty, "pop from empty queue")
    `BPCD_ASSERT_NEXT(a_pop_ends_run, i_clk, i_rst_n, w_pop, m_axis_tvalid && m_axis_tlast, "run end not flagged")
    `BPCD_ASSERT_SAME(a_off_is_last, i_clk, i_rst_n, m_axis_tvalid && (w_action == ACT_OFF), m_axis_tlast, "off command not last")

endmodule
